/* hdl/sbbe_pkg.sv */
// Package with shared types, constants and codes of the serial bus byte engine.
`timescale 1ns / 1ps
package sbbe_pkg;

  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned PreByteTicks = 50;
  localparam int unsigned PostByteTicks = 100;
  localparam int unsigned TailTicks = 100;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SEND  = 2'd1,
    FUNC_RECV  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DEV    = 2'd1,
    ST_NOT_PRES  = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_BIT_SETUP   = 3'd0,
    CFG_CLOCK_VALID = 3'd1,
    CFG_ACK_TIMEOUT = 3'd2,
    CFG_EOI_WINDOW  = 3'd3,
    CFG_EOI_ACK     = 3'd4,
    CFG_BIT_TIMEOUT = 3'd5,
    CFG_PRESENCE    = 3'd6,
    CFG_SETTLE      = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PRESENCE, PH_SETTLE, PH_PRE_BYTE, PH_LISTENER, PH_BIT_SETUP,
    PH_BIT_VALID, PH_ACK, PH_POST_BYTE, PH_TURN_WAIT, PH_TAIL,
    PH_RX_RELEASE, PH_RX_READY, PH_RX_EOI_ACK, PH_RX_TALKER, PH_RX_BIT_LOW,
    PH_RX_BIT_HIGH
  } phase_e;

  // A classified word as it travels from the front to the back.
  typedef struct packed {
    func_e      func;
    logic [7:0] byte_value;
    logic       under_atn;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       turnaround;
    logic       data_line;
    logic       clock_line;
  } cmd_t;

  typedef struct packed {
    logic       drive_data;
    logic       drive_clock;
    logic       drive_atn;
    logic       engine_busy;
    logic       op_done;
    status_e    op_status;
    logic [7:0] received_byte;
    logic       end_of_data;
  } res_t;

endpackage

/* hdl/serial_bus_byte_engine.sv */
// Top level of the serial bus byte engine: front queue, sequencer and assertions.
`timescale 1ns / 1ps
// Host side of a serial bus that moves one byte per send or receive word.
// Input words carry a function code (tick, send, receive, clear end of data)
// and the bus lines sampled once per microsecond tick. Every input word gives
// exactly one result word with the line drives, busy, done, status, the
// received byte and the sticky end-of-data flag after that word.
// Both channels use valid/ready. A two-entry queue in front parts the input
// from the sequencer, and the sequencer writes each result into an output
// register, so a new word is taken every cycle while results are drained.
// When nothing stalls, an accepted word is registered in the queue, then the
// sequencer steps it and its result is registered in the output register; the
// sustained rate is one word per cycle while the receiver takes results.
// When the receiver stalls, the output register holds, the sequencer stops,
// and the queue fills; after two more words the input drops ready.
// Reset puts all lines released, the sequencer idle, timers at zero, and the
// timing registers at their defaults. Configuration writes take effect at
// the next clock edge; the user must make them only while the block is idle,
// which the block itself does not enforce. The sampled ATN line is carried on
// the input but the host sequence never looks at it.
module serial_bus_byte_engine #(
  parameter int unsigned TimerBits = sbbe_pkg::TimerBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [sbbe_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    byte_value_i,
  input  logic                          under_atn_i,
  input  logic                          first_of_frame_i,
  input  logic                          last_of_frame_i,
  input  logic                          turnaround_i,
  input  logic                          data_line_i,
  input  logic                          clock_line_i,
  input  logic                          atn_line_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          drive_data_o,
  output logic                          drive_clock_o,
  output logic                          drive_atn_o,
  output logic                          engine_busy_o,
  output logic                          op_done_o,
  output logic [1:0]                    op_status_o,
  output logic [7:0]                    received_byte_o,
  output logic                          end_of_data_o
);
  import sbbe_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  assign in_cmd = '{func: func_e'(func_i), byte_value: byte_value_i,
                    under_atn: under_atn_i, first_of_frame: first_of_frame_i,
                    last_of_frame: last_of_frame_i, turnaround: turnaround_i,
                    data_line: data_line_i, clock_line: clock_line_i};

  sbbe_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  sbbe_back #(.TimerBits(TimerBits)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .out_res_o(res)
  );

  assign drive_data_o    = res.drive_data;
  assign drive_clock_o   = res.drive_clock;
  assign drive_atn_o     = res.drive_atn;
  assign engine_busy_o   = res.engine_busy;
  assign op_done_o       = res.op_done;
  assign op_status_o     = res.op_status;
  assign received_byte_o = res.received_byte;
  assign end_of_data_o   = res.end_of_data;

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res))
    else $error("result changed while stalled");

  // A failed or finished word never reports busy together with done.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_done_o |-> !engine_busy_o)
    else $error("done while busy");

  // Status and byte are zero without done.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !op_done_o |-> op_status_o == 2'd0 && received_byte_o == 8'd0)
    else $error("status without done");

  // The queue never refuses input while it is empty.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> in_ready_o)
    else $error("queue stuck");

endmodule

/* hdl/sbbe_front.sv */
// Input stage and two-entry queue that decouples the input from the sequencer.
`timescale 1ns / 1ps
module sbbe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sbbe_pkg::cmd_t in_cmd_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output sbbe_pkg::cmd_t q_cmd_o
);
  import sbbe_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_cmd_i;
  end

endmodule

/* hdl/sbbe_back.sv */
// Bus sequencer that carries out queued words and registers one result per word.
`timescale 1ns / 1ps
module sbbe_back #(
  parameter int unsigned TimerBits = sbbe_pkg::TimerBitsDefault
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_we_i,
  input  logic [2:0]                                     cfg_idx_i,
  input  logic [sbbe_pkg::CfgWidth-1:0]                  cfg_data_i,
  input  logic                                           q_valid_i,
  output logic                                           q_ready_o,
  input  sbbe_pkg::cmd_t                                 q_cmd_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output sbbe_pkg::res_t                                 out_res_o
);
  import sbbe_pkg::*;

  localparam logic [TimerBits-1:0] TMax = {TimerBits{1'b1}};
  localparam int unsigned CmpBits = (TimerBits > CfgWidth) ? TimerBits : CfgWidth;

  logic [CfgWidth-1:0] cfg_q [NumCfg];

  phase_e              phase_q, phase_d;
  logic [TimerBits-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic                eoi_q, eoi_d;
  logic [1:0]          rel_q, rel_d;
  logic [2:0]          ld_q, ld_d;
  logic                prev_q, prev_d;
  logic [2:0]          pf_q, pf_d;
  logic                done;
  status_e             status;
  logic [7:0]          rbyte;
  logic [CfgWidth-1:0] limit;
  logic                hit;
  logic                step;
  res_t                res_q;
  logic                ov_q;

  // The result register is free when empty or being taken.
  assign q_ready_o   = !ov_q || out_ready_i;
  assign step        = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_BIT_SETUP]   <= 16'd70;
      cfg_q[CFG_CLOCK_VALID] <= 16'd20;
      cfg_q[CFG_ACK_TIMEOUT] <= 16'd2000;
      cfg_q[CFG_EOI_WINDOW]  <= 16'd400;
      cfg_q[CFG_EOI_ACK]     <= 16'd70;
      cfg_q[CFG_BIT_TIMEOUT] <= 16'd2000;
      cfg_q[CFG_PRESENCE]    <= 16'd1000;
      cfg_q[CFG_SETTLE]      <= 16'd20000;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Limit of the timed wait in the current phase.
  always_comb begin
    case (phase_q)
      PH_PRESENCE:    limit = cfg_q[CFG_PRESENCE];
      PH_SETTLE:      limit = cfg_q[CFG_SETTLE];
      PH_PRE_BYTE:    limit = CfgWidth'(PreByteTicks);
      PH_BIT_SETUP:   limit = cfg_q[CFG_BIT_SETUP];
      PH_BIT_VALID:   limit = cfg_q[CFG_CLOCK_VALID];
      PH_ACK:         limit = cfg_q[CFG_ACK_TIMEOUT];
      PH_POST_BYTE:   limit = CfgWidth'(PostByteTicks);
      PH_TAIL:        limit = CfgWidth'(TailTicks);
      PH_RX_READY:    limit = cfg_q[CFG_EOI_WINDOW];
      PH_RX_EOI_ACK:  limit = cfg_q[CFG_EOI_ACK];
      default:        limit = cfg_q[CFG_BIT_TIMEOUT];
    endcase
  end

  always_comb begin
    tick_inc = (tick_q != TMax) ? tick_q + 1'b1 : tick_q;
    if (CmpBits'(limit) >= CmpBits'(TMax)) hit = (tick_inc == TMax);
    else hit = (CmpBits'(tick_inc) >= CmpBits'(limit));
  end

  always_comb begin
    logic data, clk, released;
    data     = q_cmd_i.data_line;
    clk      = q_cmd_i.clock_line;
    released = prev_q && !data;
    phase_d = phase_q; tick_d = tick_q; bit_d = bit_q; shift_d = shift_q;
    eoi_d = eoi_q; rel_d = rel_q; ld_d = ld_q; prev_d = prev_q; pf_d = pf_q;
    done = 1'b0; status = ST_OK; rbyte = 8'd0;
    case (q_cmd_i.func)
      FUNC_TICK: begin
        prev_d = data;
        case (phase_q)
          PH_IDLE: ;
          PH_PRESENCE: begin
            if (data) begin tick_d = '0; phase_d = PH_SETTLE; end
            else begin
              tick_d = tick_inc;
              if (hit) begin
                ld_d = ld_q & 3'b001; phase_d = PH_IDLE; done = 1'b1;
                status = ST_NO_DEV;
              end
            end
          end
          PH_SETTLE: begin
            tick_d = tick_inc;
            if (hit) begin tick_d = '0; phase_d = PH_PRE_BYTE; end
          end
          PH_PRE_BYTE: begin
            tick_d = tick_inc;
            if (hit) begin
              if (data) begin
                rel_d = (pf_q[1] && !pf_q[0]) ? 2'd2 : 2'd1;
                ld_d[1] = 1'b0; phase_d = PH_LISTENER;
              end else begin
                shift_d = 8'(ST_NOT_PRES); tick_d = '0;
                if (pf_q[2]) begin ld_d = 3'b001 | (ld_q & 3'b001); phase_d = PH_TURN_WAIT; end
                else begin ld_d[2] = 1'b0; phase_d = PH_TAIL; end
              end
            end
          end
          PH_LISTENER: begin
            if (released) begin
              rel_d = rel_q - 2'd1;
              if (rel_d == 2'd0) begin
                ld_d[1] = 1'b1; bit_d = '0; tick_d = '0; phase_d = PH_BIT_SETUP;
              end
            end
          end
          PH_BIT_SETUP: begin
            tick_d = tick_inc;
            if (hit) begin
              if (!shift_q[bit_q]) ld_d[0] = 1'b1;
              ld_d[1] = 1'b0; tick_d = '0; phase_d = PH_BIT_VALID;
            end
          end
          PH_BIT_VALID: begin
            tick_d = tick_inc;
            if (hit) begin
              ld_d[1] = 1'b1; ld_d[0] = 1'b0; tick_d = '0;
              if (bit_q == 3'd7) phase_d = PH_ACK;
              else begin bit_d = bit_q + 3'd1; phase_d = PH_BIT_SETUP; end
            end
          end
          PH_ACK: begin
            if (data) begin tick_d = '0; phase_d = PH_POST_BYTE; end
            else begin
              tick_d = tick_inc;
              if (hit) begin
                shift_d = 8'(ST_TIMEOUT); tick_d = '0;
                if (pf_q[2]) begin ld_d = 3'b001; phase_d = PH_TURN_WAIT; end
                else begin ld_d[2] = 1'b0; phase_d = PH_TAIL; end
              end
            end
          end
          PH_POST_BYTE: begin
            tick_d = tick_inc;
            if (hit) begin
              if (pf_q[1]) begin
                shift_d = 8'(ST_OK); tick_d = '0;
                if (pf_q[2]) begin ld_d = 3'b001; phase_d = PH_TURN_WAIT; end
                else begin ld_d[2] = 1'b0; phase_d = PH_TAIL; end
              end else begin
                phase_d = PH_IDLE; done = 1'b1;
              end
            end
          end
          PH_TURN_WAIT: begin
            if (clk) begin tick_d = '0; phase_d = PH_TAIL; end
          end
          PH_TAIL: begin
            tick_d = tick_inc;
            if (hit) begin phase_d = PH_IDLE; done = 1'b1; status = status_e'(shift_q[1:0]); end
          end
          PH_RX_RELEASE: begin
            if (!clk) begin ld_d[0] = 1'b0; tick_d = '0; phase_d = PH_RX_READY; end
          end
          PH_RX_READY: begin
            if (clk) begin tick_d = '0; phase_d = PH_RX_BIT_LOW; end
            else begin
              tick_d = tick_inc;
              if (hit) begin
                eoi_d = 1'b1; ld_d[0] = 1'b1; tick_d = '0; phase_d = PH_RX_EOI_ACK;
              end
            end
          end
          PH_RX_EOI_ACK: begin
            tick_d = tick_inc;
            if (hit) begin ld_d[0] = 1'b0; tick_d = '0; phase_d = PH_RX_TALKER; end
          end
          PH_RX_TALKER: begin
            if (clk) begin tick_d = '0; phase_d = PH_RX_BIT_LOW; end
            else begin
              tick_d = tick_inc;
              if (hit) begin phase_d = PH_IDLE; done = 1'b1; status = ST_TIMEOUT; end
            end
          end
          PH_RX_BIT_LOW: begin
            if (!clk) begin
              shift_d = {!data, shift_q[7:1]}; tick_d = '0; phase_d = PH_RX_BIT_HIGH;
            end else begin
              tick_d = tick_inc;
              if (hit) begin phase_d = PH_IDLE; done = 1'b1; status = ST_TIMEOUT; end
            end
          end
          PH_RX_BIT_HIGH: begin
            if (clk) begin
              tick_d = '0;
              if (bit_q == 3'd7) begin
                ld_d[0] = 1'b1; phase_d = PH_IDLE; done = 1'b1; rbyte = shift_q;
              end else begin
                bit_d = bit_q + 3'd1; phase_d = PH_RX_BIT_LOW;
              end
            end else begin
              tick_d = tick_inc;
              if (hit) begin phase_d = PH_IDLE; done = 1'b1; status = ST_TIMEOUT; end
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      FUNC_CLEAR: eoi_d = 1'b0;
      FUNC_SEND: begin
        if (phase_q == PH_IDLE) begin
          shift_d = q_cmd_i.byte_value;
          pf_d = {q_cmd_i.turnaround, q_cmd_i.last_of_frame, q_cmd_i.under_atn};
          tick_d = '0; bit_d = '0; rel_d = '0;
          if (q_cmd_i.first_of_frame) begin
            eoi_d = 1'b0;
            // ATN stays pulled if an earlier command byte left it asserted.
            ld_d = {ld_q[2] | q_cmd_i.under_atn, 1'b1, 1'b0};
            phase_d = PH_PRESENCE;
          end else begin
            phase_d = PH_PRE_BYTE;
          end
        end
      end
      default: begin
        if (phase_q == PH_IDLE) begin
          if (eoi_q) done = 1'b1;
          else begin
            shift_d = '0; bit_d = '0; tick_d = '0; phase_d = PH_RX_RELEASE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; tick_q <= '0; bit_q <= '0; shift_q <= '0;
      eoi_q <= 1'b0; rel_q <= '0; ld_q <= '0; prev_q <= 1'b0; pf_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d; tick_q <= tick_d; bit_q <= bit_d; shift_q <= shift_d;
        eoi_q <= eoi_d; rel_q <= rel_d; ld_q <= ld_d; prev_q <= prev_d; pf_q <= pf_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.drive_data    <= ld_d[0];
      res_q.drive_clock   <= ld_d[1];
      res_q.drive_atn     <= ld_d[2];
      res_q.engine_busy   <= (phase_d != PH_IDLE);
      res_q.op_done       <= done;
      res_q.op_status     <= status;
      res_q.received_byte <= rbyte;
      res_q.end_of_data   <= eoi_d;
    end
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the serial bus byte engine with a built-in bus predictor.
`timescale 1ns / 1ps
// The testbench drives input words into the serial bus byte engine and checks
// every result word against its own cycle-free model of the sequencer.
// A bus responder plays the listener and the talker. It picks the sampled
// DATA and CLK lines of each tick word from the predicted phase, so that
// most frames run through presence, settle, the listener release, eight bits
// and the acknowledge, or through a full receive. A fault setting steers it
// into each failure path: no devices, device absent, missing acknowledge,
// end of data and a stalled talker. Some noise words and commands sent while
// the engine is busy are mixed in.
// Every accepted input word gives exactly one result word, so the expected
// results live in one queue that the checker pops in order.
module testbench;
  import sbbe_pkg::*;

  localparam int LdData = 0;
  localparam int LdClk  = 1;
  localparam int LdAtn  = 2;
  localparam int PfAtn  = 0;
  localparam int PfLast = 1;
  localparam int PfTurn = 2;

  // How the bus responder misbehaves during one operation.
  typedef enum int {
    BUS_GOOD, BUS_NO_DEV, BUS_ABSENT, BUS_NO_ACK, BUS_EOI, BUS_STALL
  } bus_fault_e;

  typedef struct {
    func_e      func;
    logic [7:0] byte_value;
    logic       under_atn;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       turnaround;
    logic       data_line;
    logic       clock_line;
    logic       atn_line;
  } bus_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [CfgWidth-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i = '0;
  logic [7:0]          byte_value_i = '0;
  logic                under_atn_i = 1'b0;
  logic                first_of_frame_i = 1'b0;
  logic                last_of_frame_i = 1'b0;
  logic                turnaround_i = 1'b0;
  logic                data_line_i = 1'b0;
  logic                clock_line_i = 1'b0;
  logic                atn_line_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                drive_data_o;
  logic                drive_clock_o;
  logic                drive_atn_o;
  logic                engine_busy_o;
  logic                op_done_o;
  logic [1:0]          op_status_o;
  logic [7:0]          received_byte_o;
  logic                end_of_data_o;

  serial_bus_byte_engine DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predicted engine state and timing registers.
  phase_e      eng_phase;
  logic [15:0] eng_ticks;
  logic [2:0]  eng_bit;
  logic [7:0]  eng_shift;
  logic        eng_eoi;
  logic [1:0]  eng_releases;
  logic [2:0]  eng_drive;
  logic        eng_prev_data;
  logic [3:0]  eng_flags;
  logic [15:0] timing_regs [NumCfg];
  logic        step_done;
  status_e     step_status;
  logic [7:0]  step_byte;

  res_t        expected_results [$];
  int          mismatch_count = 0;
  int          sent_count = 0;
  bit          no_idle = 1'b0;
  int          hold_request = 0;

  function automatic logic timer_expired(input logic [15:0] limit);
    if (eng_ticks != 16'hFFFF) eng_ticks++;
    return eng_ticks >= limit;
  endfunction

  function automatic void end_operation(input status_e status);
    eng_phase   = PH_IDLE;
    step_done   = 1'b1;
    step_status = status;
  endfunction

  // The frame end keeps its status in the shift register until the tail ends.
  function automatic void start_frame_end(input status_e status);
    eng_shift = {6'd0, status};
    eng_ticks = '0;
    if (eng_flags[PfTurn]) begin
      eng_drive[LdData] = 1'b1;
      eng_drive[LdAtn]  = 1'b0;
      eng_drive[LdClk]  = 1'b0;
      eng_phase = PH_TURN_WAIT;
    end else begin
      eng_drive[LdAtn] = 1'b0;
      eng_phase = PH_TAIL;
    end
  endfunction

  function automatic void bus_tick(input logic data, input logic clk);
    logic released;
    released = eng_prev_data && !data;
    case (eng_phase)
      PH_PRESENCE: begin
        if (data) begin
          eng_ticks = '0;
          eng_phase = PH_SETTLE;
        end else if (timer_expired(timing_regs[CFG_PRESENCE])) begin
          eng_drive[LdClk] = 1'b0;
          eng_drive[LdAtn] = 1'b0;
          end_operation(ST_NO_DEV);
        end
      end
      PH_SETTLE: begin
        if (timer_expired(timing_regs[CFG_SETTLE])) begin
          eng_ticks = '0;
          eng_phase = PH_PRE_BYTE;
        end
      end
      PH_PRE_BYTE: begin
        if (timer_expired(16'(PreByteTicks))) begin
          if (data) begin
            // A data byte that ends the frame waits for two releases (EOI).
            eng_releases = (eng_flags[PfLast] && !eng_flags[PfAtn]) ? 2'd2 : 2'd1;
            eng_drive[LdClk] = 1'b0;
            eng_phase = PH_LISTENER;
          end else begin
            start_frame_end(ST_NOT_PRES);
          end
        end
      end
      PH_LISTENER: begin
        if (released) begin
          eng_releases--;
          if (eng_releases == 2'd0) begin
            eng_drive[LdClk] = 1'b1;
            eng_bit   = '0;
            eng_ticks = '0;
            eng_phase = PH_BIT_SETUP;
          end
        end
      end
      PH_BIT_SETUP: begin
        if (timer_expired(timing_regs[CFG_BIT_SETUP])) begin
          if (!eng_shift[eng_bit]) eng_drive[LdData] = 1'b1;
          eng_drive[LdClk] = 1'b0;
          eng_ticks = '0;
          eng_phase = PH_BIT_VALID;
        end
      end
      PH_BIT_VALID: begin
        if (timer_expired(timing_regs[CFG_CLOCK_VALID])) begin
          eng_drive[LdClk]  = 1'b1;
          eng_drive[LdData] = 1'b0;
          eng_ticks = '0;
          if (eng_bit == 3'd7) begin
            eng_phase = PH_ACK;
          end else begin
            eng_bit++;
            eng_phase = PH_BIT_SETUP;
          end
        end
      end
      PH_ACK: begin
        if (data) begin
          eng_ticks = '0;
          eng_phase = PH_POST_BYTE;
        end else if (timer_expired(timing_regs[CFG_ACK_TIMEOUT])) begin
          start_frame_end(ST_TIMEOUT);
        end
      end
      PH_POST_BYTE: begin
        if (timer_expired(16'(PostByteTicks))) begin
          if (eng_flags[PfLast]) start_frame_end(ST_OK);
          else end_operation(ST_OK);
        end
      end
      PH_TURN_WAIT: begin
        if (clk) begin
          eng_ticks = '0;
          eng_phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (timer_expired(16'(TailTicks))) end_operation(status_e'(eng_shift[1:0]));
      end
      PH_RX_RELEASE: begin
        if (!clk) begin
          eng_drive[LdData] = 1'b0;
          eng_ticks = '0;
          eng_phase = PH_RX_READY;
        end
      end
      PH_RX_READY: begin
        if (clk) begin
          eng_ticks = '0;
          eng_phase = PH_RX_BIT_LOW;
        end else if (timer_expired(timing_regs[CFG_EOI_WINDOW])) begin
          eng_eoi = 1'b1;
          eng_drive[LdData] = 1'b1;
          eng_ticks = '0;
          eng_phase = PH_RX_EOI_ACK;
        end
      end
      PH_RX_EOI_ACK: begin
        if (timer_expired(timing_regs[CFG_EOI_ACK])) begin
          eng_drive[LdData] = 1'b0;
          eng_ticks = '0;
          eng_phase = PH_RX_TALKER;
        end
      end
      PH_RX_TALKER: begin
        if (clk) begin
          eng_ticks = '0;
          eng_phase = PH_RX_BIT_LOW;
        end else if (timer_expired(timing_regs[CFG_BIT_TIMEOUT])) begin
          end_operation(ST_TIMEOUT);
        end
      end
      PH_RX_BIT_LOW: begin
        if (!clk) begin
          // A released DATA line is a one bit; bits come in LSB first.
          eng_shift = {~data, eng_shift[7:1]};
          eng_ticks = '0;
          eng_phase = PH_RX_BIT_HIGH;
        end else if (timer_expired(timing_regs[CFG_BIT_TIMEOUT])) begin
          end_operation(ST_TIMEOUT);
        end
      end
      PH_RX_BIT_HIGH: begin
        if (clk) begin
          eng_ticks = '0;
          if (eng_bit == 3'd7) begin
            eng_drive[LdData] = 1'b1;
            end_operation(ST_OK);
            step_byte = eng_shift;
          end else begin
            eng_bit++;
            eng_phase = PH_RX_BIT_LOW;
          end
        end else if (timer_expired(timing_regs[CFG_BIT_TIMEOUT])) begin
          end_operation(ST_TIMEOUT);
        end
      end
      default: eng_phase = PH_IDLE;
    endcase
    eng_prev_data = data;
  endfunction

  function automatic res_t predict_bus_result(input bus_word_t w);
    res_t r;
    step_done   = 1'b0;
    step_status = ST_OK;
    step_byte   = '0;
    case (w.func)
      FUNC_TICK: begin
        if (eng_phase != PH_IDLE) bus_tick(w.data_line, w.clock_line);
        else eng_prev_data = w.data_line;
      end
      FUNC_CLEAR: eng_eoi = 1'b0;
      FUNC_SEND: begin
        if (eng_phase == PH_IDLE) begin
          eng_shift    = w.byte_value;
          eng_flags    = {1'b0, w.turnaround, w.last_of_frame, w.under_atn};
          eng_ticks    = '0;
          eng_bit      = '0;
          eng_releases = '0;
          if (w.first_of_frame) begin
            eng_eoi = 1'b0;
            eng_drive[LdData] = 1'b0;
            eng_drive[LdClk]  = 1'b1;
            eng_drive[LdAtn]  = eng_drive[LdAtn] | w.under_atn;
            eng_phase = PH_PRESENCE;
          end else begin
            eng_phase = PH_PRE_BYTE;
          end
        end
      end
      default: begin
        if (eng_phase == PH_IDLE) begin
          if (eng_eoi) begin
            end_operation(ST_OK);
          end else begin
            eng_shift = '0;
            eng_bit   = '0;
            eng_ticks = '0;
            eng_phase = PH_RX_RELEASE;
          end
        end
      end
    endcase
    r.drive_data    = eng_drive[LdData];
    r.drive_clock   = eng_drive[LdClk];
    r.drive_atn     = eng_drive[LdAtn];
    r.engine_busy   = eng_phase != PH_IDLE;
    r.op_done       = step_done;
    r.op_status     = step_status;
    r.received_byte = step_byte;
    r.end_of_data   = eng_eoi;
    return r;
  endfunction

  function automatic bus_word_t random_word(input func_e func);
    bus_word_t w;
    w.func           = func;
    w.byte_value     = 8'($urandom);
    w.under_atn      = 1'($urandom);
    w.first_of_frame = 1'($urandom);
    w.last_of_frame  = 1'($urandom);
    w.turnaround     = 1'($urandom);
    w.data_line      = 1'($urandom);
    w.clock_line     = 1'($urandom);
    w.atn_line       = 1'($urandom);
    return w;
  endfunction

  // Plays the other devices on the bus: the lines follow the predicted phase.
  function automatic bus_word_t bus_response(input bus_fault_e fault);
    bus_word_t w;
    w = random_word(FUNC_TICK);
    if ($urandom_range(99) < 5) return w;
    case (eng_phase)
      PH_PRESENCE:    w.data_line  = (fault == BUS_NO_DEV) ? 1'b0 : ($urandom_range(3) != 0);
      PH_PRE_BYTE:    w.data_line  = (fault != BUS_ABSENT);
      PH_LISTENER:    w.data_line  = ~eng_prev_data;
      PH_ACK:         w.data_line  = (fault == BUS_NO_ACK) ? 1'b0 : ($urandom_range(2) == 0);
      PH_TURN_WAIT:   w.clock_line = ($urandom_range(2) == 0);
      PH_RX_READY:    w.clock_line = (fault == BUS_EOI) ? 1'b0 : ($urandom_range(3) != 0);
      PH_RX_TALKER:   w.clock_line = (fault == BUS_STALL) ? 1'b0 : ($urandom_range(2) != 0);
      PH_RX_BIT_LOW:  w.clock_line = (fault == BUS_STALL) ? 1'b1 : 1'($urandom);
      PH_RX_BIT_HIGH: w.clock_line = (fault == BUS_STALL) ? 1'b0 : 1'($urandom);
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input bus_word_t w);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 25) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    func_i           = w.func;
    byte_value_i     = w.byte_value;
    under_atn_i      = w.under_atn;
    first_of_frame_i = w.first_of_frame;
    last_of_frame_i  = w.last_of_frame;
    turnaround_i     = w.turnaround;
    data_line_i      = w.data_line;
    clock_line_i     = w.clock_line;
    atn_line_i       = w.atn_line;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_bus_result(w));
    sent_count++;
  endtask

  // Issues one command and answers with bus ticks until the engine is idle.
  task automatic run_operation(input bus_word_t cmd, input bus_fault_e fault);
    send_word(cmd);
    while (eng_phase != PH_IDLE) begin
      if ($urandom_range(99) < 2)
        send_word(random_word(func_e'($urandom_range(1, 3))));
      else
        send_word(bus_response(fault));
    end
  endtask

  task automatic wait_for_results;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Registers change only with the engine idle and every result drained.
  task automatic write_timing(input cfg_idx_e idx, input logic [15:0] value);
    wait_for_results();
    repeat (8) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    timing_regs[idx] = value;
  endtask

  task automatic write_all_timing(input int lo, input int hi);
    for (int i = 0; i < NumCfg; i++)
      write_timing(cfg_idx_e'(i), 16'($urandom_range(hi, lo)));
  endtask

  function automatic bus_word_t send_cmd(input logic [7:0] value, input logic atn,
                                         input logic first, input logic last,
                                         input logic turn);
    bus_word_t w;
    w = random_word(FUNC_SEND);
    w.byte_value     = value;
    w.under_atn      = atn;
    w.first_of_frame = first;
    w.last_of_frame  = last;
    w.turnaround     = turn;
    return w;
  endfunction

  task automatic test_long_timing;
    write_all_timing(65535, 65535);
    run_operation(random_word(FUNC_RECV), BUS_GOOD);
    run_operation(random_word(FUNC_CLEAR), BUS_GOOD);
  endtask

  task automatic test_frame_paths;
    write_all_timing(1, 1);
    run_operation(send_cmd(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0), BUS_GOOD);
    run_operation(send_cmd(8'h00, 1'b0, 1'b0, 1'b1, 1'b0), BUS_GOOD);
    run_operation(send_cmd(8'h5A, 1'b1, 1'b1, 1'b1, 1'b1), BUS_GOOD);
    run_operation(send_cmd(8'hA5, 1'b1, 1'b1, 1'b0, 1'b0), BUS_NO_DEV);
    run_operation(send_cmd(8'h3C, 1'b0, 1'b0, 1'b0, 1'b1), BUS_ABSENT);
    run_operation(send_cmd(8'hC3, 1'b0, 1'b1, 1'b0, 1'b0), BUS_NO_ACK);
    write_all_timing(3, 6);
    run_operation(random_word(FUNC_RECV), BUS_GOOD);
    run_operation(random_word(FUNC_RECV), BUS_STALL);
    run_operation(random_word(FUNC_RECV), BUS_EOI);
    // With end of data set, a receive finishes at once.
    run_operation(random_word(FUNC_RECV), BUS_GOOD);
    run_operation(random_word(FUNC_CLEAR), BUS_GOOD);
  endtask

  task automatic test_backpressure;
    int accepted;
    no_idle = 1'b1;
    hold_request = 300;
    // The engine queue fills while the output is held and stalls the input.
    run_operation(send_cmd(8'h96, 1'b0, 1'b1, 1'b1, 1'b0), BUS_GOOD);
    accepted = 0;
    while (accepted < 40) begin
      send_word(bus_response(BUS_GOOD));
      accepted++;
    end
    wait_for_results();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic;
    bus_fault_e fault;
    int         words;
    words = 0;
    while (sent_count < 2000) begin
      if (words % 600 == 0) write_all_timing(1, 8);
      no_idle = (words % 1200) >= 1000;
      fault = ($urandom_range(99) < 70) ? BUS_GOOD : bus_fault_e'($urandom_range(5, 1));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: run_operation(random_word(FUNC_SEND), fault);
        5, 6, 7:       run_operation(random_word(FUNC_RECV), fault);
        8:             run_operation(random_word(FUNC_CLEAR), fault);
        default:       send_word(bus_response(fault));
      endcase
      while (eng_phase == PH_IDLE && $urandom_range(3) == 0) begin
        send_word(random_word(FUNC_TICK));
        words++;
      end
      words += 40;
    end
    // One pause with nothing in flight before the last setting.
    wait_for_results();
    write_all_timing(1, 4);
  endtask

  // Result receiver: random stalls, plus a long hold on request.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      out_ready_i = 1'b0;
      hold_request--;
    end else begin
      out_ready_i = no_idle || ($urandom_range(99) >= 25);
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("drive_data", want.drive_data, drive_data_o);
        compare_field("drive_clock", want.drive_clock, drive_clock_o);
        compare_field("drive_atn", want.drive_atn, drive_atn_o);
        compare_field("engine_busy", want.engine_busy, engine_busy_o);
        compare_field("op_done", want.op_done, op_done_o);
        compare_field("op_status", want.op_status, op_status_o);
        compare_field("received_byte", want.received_byte, received_byte_o);
        compare_field("end_of_data", want.end_of_data, end_of_data_o);
      end
    end
  end

  initial begin
    eng_phase = PH_IDLE;
    eng_ticks = '0;
    eng_bit = '0;
    eng_shift = '0;
    eng_eoi = 1'b0;
    eng_releases = '0;
    eng_drive = '0;
    eng_prev_data = 1'b0;
    eng_flags = '0;
    timing_regs[CFG_BIT_SETUP]   = 16'd70;
    timing_regs[CFG_CLOCK_VALID] = 16'd20;
    timing_regs[CFG_ACK_TIMEOUT] = 16'd2000;
    timing_regs[CFG_EOI_WINDOW]  = 16'd400;
    timing_regs[CFG_EOI_ACK]     = 16'd70;
    timing_regs[CFG_BIT_TIMEOUT] = 16'd2000;
    timing_regs[CFG_PRESENCE]    = 16'd1000;
    timing_regs[CFG_SETTLE]      = 16'd20000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // The defaults are exercised with one receive before any write.
    run_operation(random_word(FUNC_RECV), BUS_GOOD);
    test_long_timing();
    test_frame_paths();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/sbbe_pkg.sv
hdl/sbbe_front.sv
hdl/sbbe_back.sv
hdl/serial_bus_byte_engine.sv
dv/testbench.sv
